// File: rtl/core/povcs_pkg.sv
// ----------------------------------------------------------------------------
// POV column sequencer package
// Shared widths, codes, reset values and the clock-face word function.
// ----------------------------------------------------------------------------
package povcs_pkg;

    localparam int MAX_COLUMNS_DEF = 128;
    localparam int LED_COUNT_DEF   = 16;

    localparam int LED_W       = 16;   // led_pattern / column_bits width
    localparam int IDX_W       = 7;    // column_index / shown_column width
    localparam int INDEX_SPAN  = 128;  // addresses reachable through column_index
    localparam int COL_W       = 8;    // column counter, same as columns_in_use
    localparam int TIMER_W     = 16;
    localparam int SPAN_W      = 24;   // slot bounds: up to 256 * 65535
    localparam int KIND_W      = 3;
    localparam int HOURS_W     = 4;
    localparam int MINUTES_W   = 6;
    localparam int SECONDS_W   = 6;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 24;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int DIVIDEND_W  = 16;
    localparam int DIVISOR_W   = 8;

    localparam logic [COL_W-1:0]   COLUMNS_RST = 8'd100;
    localparam logic [TIMER_W-1:0] TICKS_RST   = 16'd6500;

    localparam logic [LED_W-1:0] HAND_SECOND = 16'b1111111111111111;
    localparam logic [LED_W-1:0] HAND_MINUTE = 16'b0000111111111110;
    localparam logic [LED_W-1:0] HAND_HOUR   = 16'b0000000011111111;
    localparam int HOUR_SPACING = 6;
    localparam logic [SECONDS_W-1:0] LAST_SEC_MIN = 6'd59;
    localparam logic [HOURS_W-1:0]   LAST_HOUR    = 4'd11;

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK     = 3'd0,
        KIND_HALL     = 3'd1,
        KIND_MSEC     = 3'd2,
        KIND_WRITE    = 3'd3,
        KIND_SET_TIME = 3'd4
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COLUMNS = 2'd0,
        CFG_TICKS   = 2'd1,
        CFG_FACE    = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    // Clock-face word for one column: second hand over minute hand over hour hand.
    function automatic logic [LED_W-1:0] face_word(
        input logic [COL_W-1:0]     col,
        input logic [SECONDS_W-1:0] secs,
        input logic [MINUTES_W-1:0] mins,
        input logic [HOURS_W-1:0]   hrs
    );
        logic [COL_W-1:0] hour_col;
        hour_col = COL_W'(hrs) * COL_W'(HOUR_SPACING);
        if (col == COL_W'(secs)) begin
            return HAND_SECOND;
        end
        if (col == COL_W'(mins)) begin
            return HAND_MINUTE;
        end
        if (col == hour_col) begin
            return HAND_HOUR;
        end
        return '0;
    endfunction

endpackage

// File: rtl/core/povcs_ram.sv
// ----------------------------------------------------------------------------
// POV generic RAM
// One write port, one read port, read data registered and held between reads.
// ----------------------------------------------------------------------------
module povcs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/povcs_divider.sv
// ----------------------------------------------------------------------------
// POV slot divider
// Restoring divider, one quotient bit per cycle, done pulses for one cycle.
// ----------------------------------------------------------------------------
module povcs_divider (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [povcs_pkg::DIVIDEND_W-1:0]   dividend,
    input  logic [povcs_pkg::DIVISOR_W-1:0]    divisor,
    output povcs_pkg::div_status_t             status,
    output logic [povcs_pkg::DIVIDEND_W-1:0]   quotient
);

    localparam int DDW    = povcs_pkg::DIVIDEND_W;
    localparam int DSW    = povcs_pkg::DIVISOR_W;
    localparam int STEP_W = $clog2(DDW);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic [DSW-1:0]    rem_reg;
    logic [DSW-1:0]    rem_next;
    logic [DDW-1:0]    quo_reg;
    logic [DDW-1:0]    quo_next;
    logic [DSW-1:0]    dvs_reg;
    logic [DSW:0]      shifted;
    logic [DSW:0]      diff;
    logic              fits;

    // Shift in the next dividend bit, subtract the divisor when it fits.
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[DDW-1]};
        diff     = shifted - {1'b0, dvs_reg};
        fits     = (shifted >= {1'b0, dvs_reg});
        rem_next = fits ? diff[DSW-1:0] : shifted[DSW-1:0];
        quo_next = {quo_reg[DDW-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= STEP_W'(DDW - 1);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;

endmodule

// File: rtl/core/pov_column_sequencer_with_clock_face.sv
// ----------------------------------------------------------------------------
// POV column sequencer with clock face
// Emits LED column words for a rotating display from a column RAM or a
// generated analog clock face, paced by a rotation timer and hall pulses.
// ----------------------------------------------------------------------------
// Path: a timer tick that hits its slot reaches m_tdata through the column
//   RAM read and the pending registers, then the output register.
// Throughput: one item per cycle for every kind while the output is not
//   backed up; a hall pulse with a nonzero column count holds s_tready low
//   while the 16-step serial divider works out the slot width.
// Reset: control state and configuration take their reset values at once;
//   the column RAM is not swept, per-entry valid bits make unwritten columns
//   read as zero, so the block is ready as soon as reset is released.
// ----------------------------------------------------------------------------
module pov_column_sequencer_with_clock_face #(
    parameter int MAX_COLUMNS = povcs_pkg::MAX_COLUMNS_DEF,
    parameter int LED_COUNT   = povcs_pkg::LED_COUNT_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Input stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // [6:0] column_index, [22:7] column_bits, [26:23] set_hours,
    // [32:27] set_minutes, [38:33] set_seconds, [39] zero
    input  logic [povcs_pkg::IN_TDATA_W-1:0]     s_tdata,
    // [2:0] kind
    input  logic [povcs_pkg::KIND_W-1:0]         s_tuser,
    // Output stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [15:0] led_pattern, [22:16] shown_column, [23] zero
    output logic [povcs_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // Configuration write port
    input  logic                                 cfg_we,
    input  logic [povcs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [povcs_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int LED_W    = povcs_pkg::LED_W;
    localparam int IDX_W    = povcs_pkg::IDX_W;
    localparam int COL_W    = povcs_pkg::COL_W;
    localparam int TIMER_W  = povcs_pkg::TIMER_W;
    localparam int SPAN_W   = povcs_pkg::SPAN_W;

    // Only column_index values can ever be written, so the RAM stops there.
    localparam int STORE_DEPTH = (MAX_COLUMNS < povcs_pkg::INDEX_SPAN) ?
                                 MAX_COLUMNS : povcs_pkg::INDEX_SPAN;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);
    localparam logic [COL_W-1:0] STORE_LIMIT = COL_W'(STORE_DEPTH);

    // Column count ceiling; columns_in_use never exceeds 255 anyway.
    localparam logic [COL_W-1:0] COLUMN_CAP = (MAX_COLUMNS > 255) ?
                                              8'd255 : COL_W'(MAX_COLUMNS);

    localparam logic [LED_W-1:0] LED_MASK = (LED_COUNT >= LED_W) ? '1 :
                                            LED_W'((33'd1 << LED_COUNT) - 33'd1);

    // ------------------------------------------------------------------
    // Input field unpacking
    // ------------------------------------------------------------------
    logic [IDX_W-1:0]                  in_index;
    logic [LED_W-1:0]                  in_bits;
    logic [povcs_pkg::HOURS_W-1:0]     in_hours;
    logic [povcs_pkg::MINUTES_W-1:0]   in_minutes;
    logic [povcs_pkg::SECONDS_W-1:0]   in_seconds;

    assign in_index   = s_tdata[6:0];
    assign in_bits    = s_tdata[22:7];
    assign in_hours   = s_tdata[26:23];
    assign in_minutes = s_tdata[32:27];
    assign in_seconds = s_tdata[38:33];

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    logic [COL_W-1:0]   cfg_cols_reg,  cfg_cols_next;
    logic [TIMER_W-1:0] cfg_tps_reg,   cfg_tps_next;
    logic               cfg_face_reg,  cfg_face_next;

    logic [TIMER_W-1:0] timer_reg,     timer_next;
    logic [TIMER_W-1:0] slot_reg,      slot_next;
    logic [SPAN_W-1:0]  lo_reg,        lo_next;
    logic [SPAN_W-1:0]  hi_reg,        hi_next;
    logic [COL_W-1:0]   next_col_reg,  next_col_next;
    logic               no_turn_reg,   no_turn_next;
    logic [TIMER_W-1:0] ms_reg,        ms_next;
    logic [povcs_pkg::SECONDS_W-1:0] sec_reg, sec_next;
    logic [povcs_pkg::MINUTES_W-1:0] min_reg, min_next;
    logic [povcs_pkg::HOURS_W-1:0]   hr_reg,  hr_next;
    logic [STORE_DEPTH-1:0] valid_reg, valid_next;

    // One result in flight between RAM read and output register
    logic               pend_reg,      pend_next;
    logic               pend_face_reg, pend_face_next;
    logic               pend_hit_reg,  pend_hit_next;
    logic [LED_W-1:0]   pend_word_reg, pend_word_next;
    logic [IDX_W-1:0]   pend_col_reg,  pend_col_next;

    logic                                out_valid_reg, out_valid_next;
    logic [povcs_pkg::OUT_TDATA_W-1:0]   out_data_reg,  out_data_next;

    // ------------------------------------------------------------------
    // Column RAM and slot divider
    // ------------------------------------------------------------------
    logic                 ram_we;
    logic                 ram_re;
    logic [STORE_AW-1:0]  ram_waddr;
    logic [STORE_AW-1:0]  ram_raddr;
    logic [LED_W-1:0]     ram_rdata;

    povcs_ram #(
        .WIDTH (LED_W),
        .DEPTH (STORE_DEPTH)
    ) u_column_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (in_bits),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    logic                                div_start;
    povcs_pkg::div_status_t              div_st;
    logic [povcs_pkg::DIVIDEND_W-1:0]    div_quot;
    logic [COL_W-1:0]                    n_active;

    povcs_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (timer_reg),
        .divisor  (n_active),
        .status   (div_st),
        .quotient (div_quot)
    );

    // ------------------------------------------------------------------
    // Next-state logic
    // ------------------------------------------------------------------
    logic [TIMER_W-1:0] timer_inc;
    logic [TIMER_W-1:0] ms_inc;
    logic [SPAN_W-1:0]  timer_wide;
    logic               in_slot;
    logic               emit;
    logic               store_in_range;
    logic               write_in_range;
    logic               out_free;
    logic               in_fire;
    logic [LED_W-1:0]   word_sel;

    assign ram_raddr = next_col_reg[STORE_AW-1:0];
    assign ram_waddr = in_index[STORE_AW-1:0];

    always_comb
    begin
        n_active       = (cfg_cols_reg > COLUMN_CAP) ? COLUMN_CAP : cfg_cols_reg;
        timer_inc      = timer_reg + 1'b1;
        ms_inc         = ms_reg + 1'b1;
        timer_wide     = SPAN_W'(timer_inc);
        // lo/hi track next_column * slot_width and the bound one column on
        in_slot        = (timer_wide >= lo_reg) && (timer_wide <= hi_reg);
        emit           = !no_turn_reg && (next_col_reg < n_active) && in_slot;
        store_in_range = (next_col_reg < STORE_LIMIT);
        write_in_range = (COL_W'(in_index) < STORE_LIMIT);

        // The output register takes the pending result when it empties this cycle,
        // so a new tick can be taken alongside.
        out_free = !out_valid_reg || m_tready;
        s_tready = !div_st.busy && !div_st.done && (!pend_reg || out_free);
        in_fire  = s_tvalid && s_tready;

        word_sel = pend_face_reg ? pend_word_reg :
                   (pend_hit_reg ? ram_rdata : '0);

        cfg_cols_next  = cfg_cols_reg;
        cfg_tps_next   = cfg_tps_reg;
        cfg_face_next  = cfg_face_reg;
        timer_next     = timer_reg;
        slot_next      = slot_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        next_col_next  = next_col_reg;
        no_turn_next   = no_turn_reg;
        ms_next        = ms_reg;
        sec_next       = sec_reg;
        min_next       = min_reg;
        hr_next        = hr_reg;
        valid_next     = valid_reg;
        pend_next      = pend_reg;
        pend_face_next = pend_face_reg;
        pend_hit_next  = pend_hit_reg;
        pend_word_next = pend_word_reg;
        pend_col_next  = pend_col_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        div_start      = 1'b0;

        // Configuration registers
        if (cfg_we)
        begin
            case (cfg_index)
                povcs_pkg::CFG_COLUMNS: cfg_cols_next = cfg_wdata[COL_W-1:0];
                povcs_pkg::CFG_TICKS:   cfg_tps_next  = cfg_wdata[TIMER_W-1:0];
                povcs_pkg::CFG_FACE:    cfg_face_next = cfg_wdata[0];
                default:                ;
            endcase
        end

        // Output stage: move the pending result forward, or drop a taken one
        if (pend_reg && out_free)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {1'b0, pend_col_reg, word_sel & LED_MASK};
            pend_next      = 1'b0;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end

        // Slot width arrives from the divider after a hall pulse
        if (div_st.done)
        begin
            slot_next = div_quot;
            lo_next   = '0;
            hi_next   = SPAN_W'(div_quot);
        end

        if (in_fire)
        begin
            case (s_tuser)
                povcs_pkg::KIND_TICK:
                begin
                    timer_next = timer_inc;
                    if (emit)
                    begin
                        next_col_next  = next_col_reg + 1'b1;
                        lo_next        = hi_reg;
                        hi_next        = hi_reg + SPAN_W'(slot_reg);
                        pend_next      = 1'b1;
                        pend_col_next  = next_col_reg[IDX_W-1:0];
                        pend_face_next = cfg_face_reg;
                        pend_word_next = povcs_pkg::face_word(next_col_reg, sec_reg,
                                                              min_reg, hr_reg);
                        pend_hit_next  = store_in_range && valid_reg[ram_raddr];
                        ram_re         = !cfg_face_reg && store_in_range;
                    end
                end
                povcs_pkg::KIND_HALL:
                begin
                    timer_next    = '0;
                    no_turn_next  = 1'b0;
                    next_col_next = '0;
                    lo_next       = '0;
                    hi_next       = '0;
                    slot_next     = '0;
                    // With no columns the slot stays zero and nothing is emitted
                    div_start     = (n_active != '0);
                end
                povcs_pkg::KIND_MSEC:
                begin
                    ms_next = ms_inc;
                    if (ms_inc >= cfg_tps_reg)
                    begin
                        ms_next = '0;
                        if (sec_reg >= povcs_pkg::LAST_SEC_MIN)
                        begin
                            sec_next = '0;
                            if (min_reg >= povcs_pkg::LAST_SEC_MIN)
                            begin
                                min_next = '0;
                                hr_next  = (hr_reg >= povcs_pkg::LAST_HOUR) ?
                                           '0 : hr_reg + 1'b1;
                            end
                            else
                            begin
                                min_next = min_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            sec_next = sec_reg + 1'b1;
                        end
                    end
                end
                povcs_pkg::KIND_WRITE:
                begin
                    if (write_in_range)
                    begin
                        ram_we                = 1'b1;
                        valid_next[ram_waddr] = 1'b1;
                    end
                end
                povcs_pkg::KIND_SET_TIME:
                begin
                    hr_next  = in_hours;
                    min_next = in_minutes;
                    sec_next = in_seconds;
                end
                default:
                begin
                    // Unused kinds: accept and drop
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_cols_reg  <= povcs_pkg::COLUMNS_RST;
            cfg_tps_reg   <= povcs_pkg::TICKS_RST;
            cfg_face_reg  <= 1'b0;
            timer_reg     <= '0;
            slot_reg      <= '0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            next_col_reg  <= '0;
            no_turn_reg   <= 1'b1;
            ms_reg        <= '0;
            sec_reg       <= '0;
            min_reg       <= '0;
            hr_reg        <= '0;
            valid_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cfg_cols_reg  <= cfg_cols_next;
            cfg_tps_reg   <= cfg_tps_next;
            cfg_face_reg  <= cfg_face_next;
            timer_reg     <= timer_next;
            slot_reg      <= slot_next;
            lo_reg        <= lo_next;
            hi_reg        <= hi_next;
            next_col_reg  <= next_col_next;
            no_turn_reg   <= no_turn_next;
            ms_reg        <= ms_next;
            sec_reg       <= sec_next;
            min_reg       <= min_next;
            hr_reg        <= hr_next;
            valid_reg     <= valid_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_face_reg <= pend_face_next;
        pend_hit_reg  <= pend_hit_next;
        pend_word_reg <= pend_word_next;
        pend_col_reg  <= pend_col_next;
        out_data_reg  <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// File: rtl/core/povcs_checker.sv
// ----------------------------------------------------------------------------
// POV sequencer port checker
// Port-level assertions on the sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module povcs_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 s_tvalid,
    input logic                                 s_tready,
    input logic [povcs_pkg::IN_TDATA_W-1:0]     s_tdata,
    input logic [povcs_pkg::KIND_W-1:0]         s_tuser,
    input logic                                 m_tvalid,
    input logic                                 m_tready,
    input logic [povcs_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input logic                                 cfg_we,
    input logic [povcs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input logic [povcs_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    // Hold a stalled result.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    // A fresh result always comes from an accepted timer tick, by way of the pending and output registers.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |->
            $past(s_tvalid && s_tready && (s_tuser == povcs_pkg::KIND_TICK), 2))
        else $error("result without a timer tick");

    // Clock, write and set-time transactions never stall the input.
    a_side_items_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready &&
        ((s_tuser == povcs_pkg::KIND_MSEC) || (s_tuser == povcs_pkg::KIND_WRITE) ||
         (s_tuser == povcs_pkg::KIND_SET_TIME))
        |=> s_tready)
        else $error("input stalled after a non-display transaction");

endmodule

bind pov_column_sequencer_with_clock_face povcs_checker u_povcs_checker (.*);

// File: test/tb_pov_column_sequencer_with_clock_face.sv
// ----------------------------------------------------------------------------
// POV column sequencer testbench
// Drives timer ticks, hall pulses, millisecond ticks, column writes and time
// loads into the sequencer, predicts every LED column word it should emit and
// checks the output stream word by word, under random idling on both sides.
// ----------------------------------------------------------------------------
module tb_pov_column_sequencer_with_clock_face;

    import povcs_pkg::*;

    localparam int HALF_PERIOD      = 10;
    localparam int RESET_CYCLES     = 10;
    localparam int SETTLE_CYCLES    = 24;     // hall divider plus output pipeline
    localparam int RANDOM_PHASES    = 6;
    localparam int PHASE_ITEMS      = 325;
    localparam int HOLD_OFF_CYCLES  = 400;
    localparam int WRAP_TICKS       = 65536;
    localparam int NOISE_PCT        = 12;
    localparam longint RUN_LIMIT    = 40000000;

    // Kinds 5 to 7 carry no meaning; the block must ignore them
    localparam logic [KIND_W-1:0] KIND_SPARE_FIRST = 3'd5;
    localparam logic [KIND_W-1:0] KIND_SPARE_LAST  = 3'd7;

    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [IDX_W-1:0]     column_index;
        logic [LED_W-1:0]     column_bits;
        logic [HOURS_W-1:0]   set_hours;
        logic [MINUTES_W-1:0] set_minutes;
        logic [SECONDS_W-1:0] set_seconds;
    } pov_item_t;

    typedef struct packed {
        logic [LED_W-1:0] led_pattern;
        logic [IDX_W-1:0] shown_column;
    } column_word_t;

    // How a directed row is judged: by the predictor, as "no word", or as a
    // word typed into the table
    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_NONE,
        CHK_WORD
    } row_check_t;

    typedef struct packed {
        logic                  is_cfg;
        cfg_idx_t              cfg_sel;
        logic [CFG_DATA_W-1:0] cfg_val;
        pov_item_t             item;
        row_check_t            check;
        column_word_t          want;
    } stim_row_t;

    localparam pov_item_t    NO_ITEM = '0;
    localparam column_word_t NO_WORD = '0;

    // Directed table: extremes of every field, every kind, and the corner
    // cases (no turn yet, end of turn, zero slot width, capped and zero
    // column count, zero ticks per second, out-of-range time, spare kind).
    // Fields: is_cfg, register, value, item, check, expected word
    localparam stim_row_t DIRECTED [24] = '{
        '{1'b1, CFG_COLUMNS, 16'd1, NO_ITEM, CHK_NONE, NO_WORD},
        '{1'b0, CFG_COLUMNS, 16'd0,
          '{KIND_TICK, 7'd0, 16'h0000, 4'd0, 6'd0, 6'd0}, CHK_NONE, NO_WORD},
        '{1'b0, CFG_COLUMNS, 16'd0,
          '{KIND_WRITE, 7'd0, 16'hFFFF, 4'd0, 6'd0, 6'd0}, CHK_NONE, NO_WORD},
        '{1'b0, CFG_COLUMNS, 16'd0,
          '{KIND_WRITE, 7'd127, 16'h0000, 4'hF, 6'h3F, 6'h3F}, CHK_NONE, NO_WORD},
        '{1'b0, CFG_COLUMNS, 16'd0,
          '{KIND_WRITE, 7'd1, 16'h8001, 4'd0, 6'd0, 6'd0}, CHK_NONE, NO_WORD},
        '{1'b0, CFG_COLUMNS, 16'd0,
          '{KIND_HALL, 7'd0, 16'h0000, 4'd0, 6'd0, 6'd0}, CHK_NONE, NO_WORD},
        '{1'b0, CFG_COLUMNS, 16'd0,
          '{KIND_TICK, 7'd0, 16'h0000, 4'd0, 6'd0, 6'd0}, CHK_WORD, '{16'hFFFF, 7'd0}},
        '{1'b0, CFG_COLUMNS, 16'd0,
          '{KIND_TICK, 7'd0, 16'h0000, 4'd0, 6'd0, 6'd0}, CHK_NONE, NO_WORD},
        '{1'b0, CFG_COLUMNS, 16'd0,
          '{KIND_SET_TIME, 7'd127, 16'hFFFF, 4'hF, 6'h3F, 6'h3F}, CHK_NONE, NO_WORD},
        '{1'b1, CFG_TICKS, 16'd0, NO_ITEM, CHK_NONE, NO_WORD},
        '{1'b1, CFG_FACE, 16'd1, NO_ITEM, CHK_NONE, NO_WORD},
        '{1'b0, CFG_COLUMNS, 16'd0,
          '{KIND_MSEC, 7'd0, 16'h0000, 4'd0, 6'd0, 6'd0}, CHK_NONE, NO_WORD},
        '{1'b1, CFG_COLUMNS, 16'd100, NO_ITEM, CHK_NONE, NO_WORD},
        '{1'b0, CFG_COLUMNS, 16'd0,
          '{KIND_HALL, 7'd0, 16'h0000, 4'd0, 6'd0, 6'd0}, CHK_NONE, NO_WORD},
        '{1'b0, CFG_COLUMNS, 16'd0,
          '{KIND_TICK, 7'd0, 16'h0000, 4'd0, 6'd0, 6'd0}, CHK_NONE, NO_WORD},
        '{1'b0, CFG_COLUMNS, 16'd0,
          '{KIND_SET_TIME, 7'd0, 16'h0000, 4'd11, 6'd59, 6'd59}, CHK_NONE, NO_WORD},
        '{1'b1, CFG_COLUMNS, 16'd255, NO_ITEM, CHK_NONE, NO_WORD},
        '{1'b1, CFG_TICKS, 16'd1, NO_ITEM, CHK_NONE, NO_WORD},
        '{1'b0, CFG_COLUMNS, 16'd0,
          '{KIND_MSEC, 7'd0, 16'h0000, 4'd0, 6'd0, 6'd0}, CHK_MODEL, NO_WORD},
        '{1'b0, CFG_COLUMNS, 16'd0,
          '{KIND_SPARE_LAST, 7'h7F, 16'hFFFF, 4'hF, 6'h3F, 6'h3F}, CHK_NONE, NO_WORD},
        '{1'b1, CFG_COLUMNS, 16'd0, NO_ITEM, CHK_NONE, NO_WORD},
        '{1'b0, CFG_COLUMNS, 16'd0,
          '{KIND_HALL, 7'd0, 16'h0000, 4'd0, 6'd0, 6'd0}, CHK_NONE, NO_WORD},
        '{1'b0, CFG_COLUMNS, 16'd0,
          '{KIND_TICK, 7'd0, 16'h0000, 4'd0, 6'd0, 6'd0}, CHK_NONE, NO_WORD},
        '{1'b0, CFG_COLUMNS, 16'd0,
          '{KIND_TICK, 7'd0, 16'h0000, 4'd0, 6'd0, 6'd0}, CHK_MODEL, NO_WORD}
    };

    // ------------------------------------------------------------------------
    // Block ports; every input holds a known value from time zero
    // ------------------------------------------------------------------------
    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic [KIND_W-1:0]      s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    // Run bookkeeping
    column_word_t pending_columns [$];
    int           fails          = 0;
    int           words_checked  = 0;
    int           items_sent     = 0;
    int           cfg_writes     = 0;
    int unsigned  send_idle_pct  = 0;
    int unsigned  recv_idle_pct  = 0;
    logic         hold_off_req   = 1'b0;
    bit           hold_off_taken = 1'b0;
    int           hold_left      = 0;

    // Predictor copy of the configuration and state, at reset values
    logic [COL_W-1:0]     cfg_cols      = COLUMNS_RST;
    logic [TIMER_W-1:0]   cfg_tps       = TICKS_RST;
    logic                 cfg_face      = 1'b0;
    logic [TIMER_W-1:0]   spin_timer    = '0;
    logic [TIMER_W-1:0]   rev_period    = '0;
    logic [TIMER_W-1:0]   slot_len      = '0;
    logic [COL_W-1:0]     col_ptr       = '0;
    logic                 awaiting_turn = 1'b1;
    logic [TIMER_W-1:0]   msec_acc      = '0;
    logic [SECONDS_W-1:0] t_sec         = '0;
    logic [MINUTES_W-1:0] t_min         = '0;
    logic [HOURS_W-1:0]   t_hr          = '0;
    logic [LED_W-1:0]     col_ram [INDEX_SPAN];

    pov_column_sequencer_with_clock_face i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // Hard stop in case the block hangs a handshake
    initial
    begin
        #(RUN_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Clock-face word: second hand over minute hand over hour hand
    function automatic logic [LED_W-1:0] hand_pattern(input int unsigned c);
        if (c == t_sec)
        begin
            return HAND_SECOND;
        end
        if (c == t_min)
        begin
            return HAND_MINUTE;
        end
        if (c == t_hr * HOUR_SPACING)
        begin
            return HAND_HOUR;
        end
        return '0;
    endfunction

    // Advance the predicted state by one accepted transaction and report the
    // column word it produces, if any
    task automatic predict_column(input pov_item_t it, output bit hit,
                                  output column_word_t w);
        int unsigned n;
        int unsigned lo;
        int unsigned hi;
        hit = 1'b0;
        w   = '0;
        // Cap the column count at the store size
        n = (cfg_cols > MAX_COLUMNS_DEF) ? MAX_COLUMNS_DEF : cfg_cols;
        case (it.kind)
            KIND_TICK:
            begin
                spin_timer = spin_timer + 1'b1;    // wraps at 16 bits
                if (!awaiting_turn && col_ptr < n)
                begin
                    lo = 32'(col_ptr) * 32'(slot_len);
                    hi = (32'(col_ptr) + 1) * 32'(slot_len);
                    if (spin_timer >= lo && spin_timer <= hi)
                    begin
                        hit = 1'b1;
                        w.led_pattern  = cfg_face ? hand_pattern(col_ptr) : col_ram[col_ptr];
                        w.shown_column = col_ptr[IDX_W-1:0];
                        col_ptr = col_ptr + 1'b1;
                    end
                end
            end
            KIND_HALL:
            begin
                rev_period    = spin_timer;
                spin_timer    = '0;
                awaiting_turn = 1'b0;
                col_ptr       = '0;
                slot_len      = (n != 0) ? TIMER_W'(32'(rev_period) / n) : '0;
            end
            KIND_MSEC:
            begin
                msec_acc = msec_acc + 1'b1;
                if (msec_acc >= cfg_tps)
                begin
                    msec_acc = '0;
                    // Carry seconds into minutes into hours, 12-hour wrap
                    if (t_sec >= LAST_SEC_MIN)
                    begin
                        t_sec = '0;
                        if (t_min >= LAST_SEC_MIN)
                        begin
                            t_min = '0;
                            t_hr  = (t_hr >= LAST_HOUR) ? '0 : t_hr + 1'b1;
                        end
                        else
                        begin
                            t_min = t_min + 1'b1;
                        end
                    end
                    else
                    begin
                        t_sec = t_sec + 1'b1;
                    end
                end
            end
            KIND_WRITE:
            begin
                col_ram[it.column_index] = it.column_bits;
            end
            KIND_SET_TIME:
            begin
                t_hr  = it.set_hours;
                t_min = it.set_minutes;
                t_sec = it.set_seconds;
            end
            default:
            begin
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------

    // Offer one transaction, idling first at the current rate, and record
    // what it should produce once accepted. Leave tvalid high on return.
    task automatic send_item(input pov_item_t it, input row_check_t chk,
                             input column_word_t want);
        bit           hit;
        column_word_t w;
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.kind;
        s_tdata  <= {1'b0, it.set_seconds, it.set_minutes, it.set_hours,
                     it.column_bits, it.column_index};
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        predict_column(it, hit, w);
        if (chk == CHK_WORD)
        begin
            pending_columns.push_back(want);
        end
        else if (chk == CHK_MODEL && hit)
        begin
            pending_columns.push_back(w);
        end
        if (it.kind <= KIND_SET_TIME)
        begin
            items_sent++;
        end
    endtask

    // Drop tvalid, drain every expected word, then let a hall divide finish
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_columns.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register write; the task returns with cfg_we low again
    task automatic write_reg(input cfg_idx_t sel, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= sel;
        cfg_wdata <= val;
        case (sel)
            CFG_COLUMNS: cfg_cols = val[COL_W-1:0];
            CFG_TICKS:   cfg_tps  = val;
            CFG_FACE:    cfg_face = val[0];
            default:
            begin
            end
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
        cfg_writes++;
        @(posedge clk);
    endtask

    task automatic apply_setting(input logic [CFG_DATA_W-1:0] cols,
                                 input logic [CFG_DATA_W-1:0] tps,
                                 input logic [CFG_DATA_W-1:0] face);
        write_reg(CFG_COLUMNS, cols);
        write_reg(CFG_TICKS, tps);
        write_reg(CFG_FACE, face);
    endtask

    // Random content in every field; time loads stay mostly in range so the
    // clock hands land on real columns
    function automatic pov_item_t random_item(input logic [KIND_W-1:0] kind);
        pov_item_t it;
        it.kind         = kind;
        it.column_index = IDX_W'($urandom);
        it.column_bits  = LED_W'($urandom);
        it.set_hours    = HOURS_W'($urandom);
        it.set_minutes  = MINUTES_W'($urandom);
        it.set_seconds  = SECONDS_W'($urandom);
        if (kind == KIND_SET_TIME && $urandom_range(3, 0) != 0)
        begin
            it.set_hours   = HOURS_W'($urandom_range(LAST_HOUR, 0));
            it.set_minutes = MINUTES_W'($urandom_range(LAST_SEC_MIN, 0));
            it.set_seconds = SECONDS_W'($urandom_range(LAST_SEC_MIN, 0));
        end
        return it;
    endfunction

    // One turn: a hall pulse, then a run of timer ticks sized to the column
    // count so most columns get shown, sprinkled with other kinds. Now and
    // then the turn is cut short to break the sequence.
    task automatic run_turn();
        int unsigned n;
        int unsigned span;
        int unsigned pick;
        logic [KIND_W-1:0] noise_kind;
        n = (cfg_cols > MAX_COLUMNS_DEF) ? MAX_COLUMNS_DEF : cfg_cols;
        send_item(random_item(KIND_HALL), CHK_MODEL, NO_WORD);
        if (n == 0)
        begin
            span = $urandom_range(20, 1);
        end
        else if ($urandom_range(9, 0) == 0)
        begin
            span = $urandom_range(n, 0);
        end
        else
        begin
            span = $urandom_range(3 * n + 10, n);
        end
        for (int i = 0; i < span; i++)
        begin
            if ($urandom_range(99, 0) < NOISE_PCT)
            begin
                pick = $urandom_range(9, 0);
                if (pick < 5)
                begin
                    noise_kind = KIND_MSEC;
                end
                else if (pick < 7)
                begin
                    noise_kind = KIND_WRITE;
                end
                else if (pick < 9)
                begin
                    noise_kind = KIND_SET_TIME;
                end
                else
                begin
                    noise_kind = KIND_W'($urandom_range(KIND_SPARE_LAST, KIND_SPARE_FIRST));
                end
                send_item(random_item(noise_kind), CHK_MODEL, NO_WORD);
            end
            send_item(random_item(KIND_TICK), CHK_MODEL, NO_WORD);
        end
    endtask

    // ------------------------------------------------------------------------
    // Output side: check each accepted word, then pick the next tready
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : rx_side
        column_word_t got;
        column_word_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.led_pattern  = m_tdata[LED_W-1:0];
                got.shown_column = m_tdata[LED_W +: IDX_W];
                if (pending_columns.size() == 0)
                begin
                    $error("unexpected column word: led_pattern %h shown_column %0d",
                           got.led_pattern, got.shown_column);
                    fails++;
                end
                else
                begin
                    want = pending_columns.pop_front();
                    words_checked++;
                    if (got.led_pattern !== want.led_pattern)
                    begin
                        $error("led_pattern mismatch: expected %h, actual %h",
                               want.led_pattern, got.led_pattern);
                        fails++;
                    end
                    if (got.shown_column !== want.shown_column)
                    begin
                        $error("shown_column mismatch: expected %0d, actual %0d",
                               want.shown_column, got.shown_column);
                        fails++;
                    end
                end
            end
            // Long hold-off on request so the block backs up into its input
            if (hold_off_req && !hold_off_taken)
            begin
                hold_off_taken = 1'b1;
                hold_left      = HOLD_OFF_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int target;
        foreach (col_ram[i])
        begin
            col_ram[i] = '0;
        end
        send_idle_pct = 25;
        recv_idle_pct = 75;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows; registers change only once the block is quiet
        foreach (DIRECTED[r])
        begin
            if (DIRECTED[r].is_cfg)
            begin
                settle();
                write_reg(DIRECTED[r].cfg_sel, DIRECTED[r].cfg_val);
            end
            else
            begin
                send_item(DIRECTED[r].item, DIRECTED[r].check, DIRECTED[r].want);
            end
        end

        // Random phases: sender idles 25 / receiver 75, then the reverse,
        // then no idling at all; each phase runs its own setting
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            settle();
            send_idle_pct = (p < 2) ? 25 : (p < 4) ? 75 : 0;
            recv_idle_pct = (p < 2) ? 75 : (p < 4) ? 25 : 0;
            case (p)
                0: apply_setting(16'd8, 16'd3, 16'd0);
                1: apply_setting(16'd128, 16'd1, 16'd1);
                2: apply_setting(16'd255, 16'd65535, 16'd0);
                3: apply_setting(16'd1, 16'd0, 16'd1);
                4: apply_setting(16'($urandom_range(MAX_COLUMNS_DEF, 2)),
                                 16'($urandom_range(20, 1)), 16'd1);
                default: apply_setting(16'($urandom_range(60, 2)), 16'd2, 16'd0);
            endcase
            // Stall the receiver hard while the sender runs flat out
            if (p == 4)
            begin
                hold_off_req <= 1'b1;
            end
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target)
            begin
                run_turn();
            end
        end

        // Timer wrap: two back-to-back hall pulses give a zero slot width,
        // so only the tick that wraps the timer to zero shows column 0
        settle();
        write_reg(CFG_COLUMNS, 16'(MAX_COLUMNS_DEF));
        send_item(random_item(KIND_HALL), CHK_MODEL, NO_WORD);
        send_item(random_item(KIND_HALL), CHK_MODEL, NO_WORD);
        repeat (WRAP_TICKS) send_item(random_item(KIND_TICK), CHK_MODEL, NO_WORD);

        settle();
        $display("Covered %0d input transactions and %0d column words checked,",
                 items_sent, words_checked);
        $display("over %0d register writes, a long output stall and a timer wrap.",
                 cfg_writes);
        if (fails == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
